### hw/rtl/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg: shared types and constants of the tick timer
// Item structs, register select codes and the period constants.
// ----------------------------------------------------------------------------
package tt_pkg;

  localparam int unsigned CPU_CLOCK_HZ    = 4194304;
  localparam int unsigned DIVIDER_RATE_HZ = 16384;

  // selectable counter rates, indexed by control bits 1:0
  localparam int unsigned FREQ_0 = 4096;
  localparam int unsigned FREQ_1 = 262144;
  localparam int unsigned FREQ_2 = 65536;
  localparam int unsigned FREQ_3 = 16384;

  // a period that truncates to zero is used as one
  localparam int unsigned DIV_PERIOD_RAW = CPU_CLOCK_HZ / DIVIDER_RATE_HZ;
  localparam int unsigned DIV_PERIOD     = (DIV_PERIOD_RAW == 0) ? 1 : DIV_PERIOD_RAW;
  localparam int unsigned CNT_PERIOD_0   = (CPU_CLOCK_HZ / FREQ_0 == 0) ? 1 : CPU_CLOCK_HZ / FREQ_0;
  localparam int unsigned CNT_PERIOD_1   = (CPU_CLOCK_HZ / FREQ_1 == 0) ? 1 : CPU_CLOCK_HZ / FREQ_1;
  localparam int unsigned CNT_PERIOD_2   = (CPU_CLOCK_HZ / FREQ_2 == 0) ? 1 : CPU_CLOCK_HZ / FREQ_2;
  localparam int unsigned CNT_PERIOD_3   = (CPU_CLOCK_HZ / FREQ_3 == 0) ? 1 : CPU_CLOCK_HZ / FREQ_3;

  localparam int unsigned DIV_ACC_W = 10;
  localparam int unsigned CNT_ACC_W = 16;

  localparam logic [1:0] CTL_RATE_MASK = 2'b11;
  localparam int unsigned CTL_RUN_BIT  = 2;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_DIV = 2'd0,
    REG_CNT = 2'd1,
    REG_MOD = 2'd2,
    REG_CTL = 2'd3
  } reg_sel_e;

  typedef struct packed {
    logic [0:0] opcode;
    logic [1:0] reg_select;
    logic [7:0] write_value;
    logic [7:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] divider_value;
    logic [7:0] counter_value;
    logic [7:0] modulo_value;
    logic [7:0] control_value;
    logic [0:0] timer_irq;
  } out_item_t;

  function automatic logic [CNT_ACC_W-1:0] cnt_period(input logic [1:0] rate);
    logic [CNT_ACC_W-1:0] p;
    case (rate)
      2'd0:    p = CNT_ACC_W'(CNT_PERIOD_0);
      2'd1:    p = CNT_ACC_W'(CNT_PERIOD_1);
      2'd2:    p = CNT_ACC_W'(CNT_PERIOD_2);
      default: p = CNT_ACC_W'(CNT_PERIOD_3);
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/tt_in_stage.sv
// ----------------------------------------------------------------------------
// tt_in_stage: input register of the tick timer
// Captures one item per cycle unless stalled, holds it until the core takes it.
// ----------------------------------------------------------------------------
module tt_in_stage import tt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     fwd_valid_o,
  output in_item_t fwd_item_o,
  input  logic     fwd_ready_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !fwd_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (fwd_ready_i || !valid_q) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign fwd_valid_o = valid_q;
  assign fwd_item_o  = item_q;

endmodule

### hw/rtl/tt_core.sv
// ----------------------------------------------------------------------------
// tt_core: timer state and result register
// Applies one write or tick per cycle unless stalled and registers the state.
// ----------------------------------------------------------------------------
module tt_core import tt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  in_item_t  item_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [7:0]           divider_q, divider_d;
  logic [7:0]           counter_q, counter_d;
  logic [7:0]           modulo_q, modulo_d;
  logic [7:0]           control_q, control_d;
  logic [DIV_ACC_W-1:0] div_acc_q, div_acc_d;
  logic [CNT_ACC_W-1:0] cnt_acc_q, cnt_acc_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q;
  logic                 irq;
  logic                 fire;

  logic [DIV_ACC_W-1:0] div_sum;
  logic                 div_step;
  logic [CNT_ACC_W:0]   cnt_sum;
  logic [CNT_ACC_W-1:0] cnt_sat;
  logic [CNT_ACC_W-1:0] period;
  logic [7:0]           cnt_inc;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign fire    = item_valid_i && ready_o;

  always_comb begin
    // remainder stays below the period, so one subtract settles the quotient
    div_sum  = div_acc_q + DIV_ACC_W'(item_i.tick_cycles);
    div_step = div_sum >= DIV_ACC_W'(DIV_PERIOD);
    cnt_sum  = {1'b0, cnt_acc_q} + (CNT_ACC_W + 1)'(item_i.tick_cycles);
    cnt_sat  = cnt_sum[CNT_ACC_W] ? {CNT_ACC_W{1'b1}} : cnt_sum[CNT_ACC_W-1:0];
    period   = cnt_period(control_q[1:0]);
    cnt_inc  = counter_q + 8'd1;
  end

  always_comb begin
    divider_d = divider_q;
    counter_d = counter_q;
    modulo_d  = modulo_q;
    control_d = control_q;
    div_acc_d = div_acc_q;
    cnt_acc_d = cnt_acc_q;
    irq       = 1'b0;
    if (item_i.opcode == OP_WRITE) begin
      case (reg_sel_e'(item_i.reg_select))
        REG_DIV: divider_d = 8'd0;
        REG_CNT: counter_d = item_i.write_value;
        REG_MOD: modulo_d  = item_i.write_value;
        REG_CTL: begin
          control_d = item_i.write_value;
          // rate change or timer switched on restarts both accumulators
          if ((control_q[1:0] & CTL_RATE_MASK) != (item_i.write_value[1:0] & CTL_RATE_MASK) ||
              (!control_q[CTL_RUN_BIT] && item_i.write_value[CTL_RUN_BIT])) begin
            div_acc_d = '0;
            cnt_acc_d = '0;
          end
        end
        default: ;
      endcase
    end else begin
      div_acc_d = div_step ? div_sum - DIV_ACC_W'(DIV_PERIOD) : div_sum;
      divider_d = divider_q + {7'd0, div_step};
      cnt_acc_d = cnt_sat;
      if (control_q[CTL_RUN_BIT] && cnt_sat >= period) begin
        cnt_acc_d = cnt_sat - period;
        if (cnt_inc == 8'd0) begin
          counter_d = modulo_q;
          irq       = 1'b1;
        end else begin
          counter_d = cnt_inc;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ready_o) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q   <= '0;
      counter_q   <= '0;
      modulo_q    <= '0;
      control_q   <= '0;
      div_acc_q   <= '0;
      cnt_acc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        divider_q <= divider_d;
        counter_q <= counter_d;
        modulo_q  <= modulo_d;
        control_q <= control_d;
        div_acc_q <= div_acc_d;
        cnt_acc_q <= cnt_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q.divider_value <= divider_d;
      out_item_q.counter_value <= counter_d;
      out_item_q.modulo_value  <= modulo_d;
      out_item_q.control_value <= control_d;
      out_item_q.timer_irq     <= irq;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hw/rtl/tick_timer_with_reload.sv
// ----------------------------------------------------------------------------
// tick_timer_with_reload: divider / counter / modulo / control timer
// Each input item is a register write or a tick of elapsed machine cycles,
// and each yields one result with the register state after it.
//
// Input channel: in_valid_i / in_stall_o carry in_item_i; a transfer occurs
// when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i carry out_item_o in the same way.
// Each item passes the input register, then its result the result register.
// Throughput: one item per cycle unless stalled; the state update is a few
// adds and compares between the input register and the result register.
// Reset clears all timer registers, both accumulators and both valid flags.
// While the receiver stalls the result register holds; the input register
// still takes an item if empty, then in_stall_o rises until the result moves.
// ----------------------------------------------------------------------------
module tick_timer_with_reload import tt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     fwd_valid;
  logic     fwd_ready;
  in_item_t fwd_item;

  tt_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .fwd_valid_o (fwd_valid),
    .fwd_item_o  (fwd_item),
    .fwd_ready_i (fwd_ready)
  );

  tt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fwd_valid),
    .item_i       (fwd_item),
    .ready_o      (fwd_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

### hw/rtl/tt_checker.sv
// ----------------------------------------------------------------------------
// tt_checker: port-level checks of the tick timer
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
module tt_checker import tt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a reload leaves the counter at the modulo value
  a_irq_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.timer_irq |-> out_item_o.counter_value == out_item_o.modulo_value)
    else $error("irq without reload to modulo");

  // with the result register empty nothing blocks the input side
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register empty");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an input transfer with no receiver stall meanwhile yields a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after input transfer");

endmodule

bind tick_timer_with_reload tt_checker u_tt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### bench/tick_timer_with_reload_tb.sv
// ----------------------------------------------------------------------------
// tick_timer_with_reload_tb: self-checking bench for the tick timer
// Sends register writes and ticks through the valid/stall input channel and
// predicts the register state after each transfer; every result is compared
// field by field in order. Sender bursts and receiver stalls are random, with
// one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tick_timer_with_reload_tb;
  import tt_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned HOLD_CYCLES  = 120;

  // tracks the timer registers and holds the results still owed by the block
  class timer_scoreboard;
    logic [7:0]  div_q   = '0;
    logic [7:0]  cnt_q   = '0;
    logic [7:0]  mod_q   = '0;
    logic [7:0]  ctl_q   = '0;
    logic        run_q   = 1'b0;
    logic [9:0]  div_acc = '0;
    logic [15:0] cnt_acc = '0;
    int unsigned rate_hz[4] = '{FREQ_0, FREQ_1, FREQ_2, FREQ_3};
    out_item_t   regs_due[$];
    int unsigned results_seen = 0;
    int unsigned errors = 0;

    function int unsigned rate_ticks(logic [1:0] rate);
      int unsigned p;
      p = CPU_CLOCK_HZ / rate_hz[rate];
      return (p == 0) ? 1 : p;
    endfunction

    function int unsigned divider_ticks();
      int unsigned p;
      p = CPU_CLOCK_HZ / DIVIDER_RATE_HZ;
      return (p == 0) ? 1 : p;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t   r;
      logic [1:0]  old_rate;
      logic        was_on;
      logic [9:0]  dsum;
      logic [16:0] csum;
      int unsigned cp;
      r.timer_irq = 1'b0;
      if (it.opcode == OP_WRITE) begin
        case (reg_sel_e'(it.reg_select))
          REG_DIV: div_q = '0;
          REG_CNT: cnt_q = it.write_value;
          REG_MOD: mod_q = it.write_value;
          REG_CTL: begin
            was_on   = run_q;
            old_rate = ctl_q[1:0] & CTL_RATE_MASK;
            ctl_q    = it.write_value;
            run_q    = it.write_value[CTL_RUN_BIT];
            // new rate or timer switched on restarts both accumulators
            if (old_rate != (it.write_value[1:0] & CTL_RATE_MASK) || (!was_on && run_q)) begin
              div_acc = '0;
              cnt_acc = '0;
            end
          end
          default: ;
        endcase
      end else begin
        dsum    = div_acc + 10'(it.tick_cycles);
        div_q   = div_q + 8'(dsum / divider_ticks());
        div_acc = 10'(dsum % divider_ticks());
        csum    = {1'b0, cnt_acc} + 17'(it.tick_cycles);
        cnt_acc = csum[16] ? 16'hFFFF : csum[15:0];
        cp      = rate_ticks(ctl_q[1:0]);
        // one counter step per tick at most, reload on wrap
        if (run_q && cnt_acc >= cp) begin
          cnt_q = cnt_q + 8'd1;
          if (cnt_q == 8'd0) begin
            cnt_q       = mod_q;
            r.timer_irq = 1'b1;
          end
          cnt_acc = cnt_acc - 16'(cp);
        end
      end
      r.divider_value = div_q;
      r.counter_value = cnt_q;
      r.modulo_value  = mod_q;
      r.control_value = ctl_q;
      regs_due.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (regs_due.size() == 0) begin
        $error("result with no transfer pending: %h", got);
        errors++;
        return;
      end
      want = regs_due.pop_front();
      if (got.divider_value !== want.divider_value) begin
        $error("divider_value: expected %0d, got %0d", want.divider_value, got.divider_value);
        errors++;
      end
      if (got.counter_value !== want.counter_value) begin
        $error("counter_value: expected %0d, got %0d", want.counter_value, got.counter_value);
        errors++;
      end
      if (got.modulo_value !== want.modulo_value) begin
        $error("modulo_value: expected %0d, got %0d", want.modulo_value, got.modulo_value);
        errors++;
      end
      if (got.control_value !== want.control_value) begin
        $error("control_value: expected %0h, got %0h", want.control_value, got.control_value);
        errors++;
      end
      if (got.timer_irq !== want.timer_irq) begin
        $error("timer_irq: expected %0d, got %0d", want.timer_irq, got.timer_irq);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  timer_scoreboard sb = new();
  in_item_t        stim_q[$];
  int unsigned     cycle_cnt = 0;

  tick_timer_with_reload i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // register fields are don't-care on a tick, and cycles on a write
  function automatic void push_tick(int unsigned cyc);
    in_item_t it;
    it.opcode      = OP_TICK;
    it.reg_select  = 2'($urandom);
    it.write_value = 8'($urandom);
    it.tick_cycles = 8'(cyc);
    stim_q.push_back(it);
  endfunction

  function automatic void push_write(reg_sel_e sel, logic [7:0] val);
    in_item_t it;
    it.opcode      = OP_WRITE;
    it.reg_select  = sel;
    it.write_value = val;
    it.tick_cycles = 8'($urandom);
    stim_q.push_back(it);
  endfunction

  // mostly ticks; counter and modulo lean high so the counter wraps often
  function automatic void push_mixed(int unsigned n);
    reg_sel_e   sel;
    logic [7:0] val;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (pick < 8)       push_tick(0);
        else if (pick < 16) push_tick(255);
        else                push_tick($urandom_range(0, 255));
      end else begin
        sel = reg_sel_e'($urandom_range(0, 3));
        if ((sel == REG_CNT || sel == REG_MOD) && $urandom_range(0, 1))
          val = 8'($urandom_range(224, 255));
        else
          val = 8'($urandom);
        push_write(sel, val);
      end
    end
  endfunction

  task automatic offer(input in_item_t it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(it);
  endtask

  // results are taken on the edge where valid is high and stall is low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : receiver
    int unsigned left;
    int unsigned mode;
    bit          hold_done;
    left      = 0;
    mode      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      // one long hold-off so the block fills and pushes back on the sender
      if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 80);
      end
      left--;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  initial begin : stimulus
    int unsigned burst;
    int unsigned gap;

    // directed: extremes, every register, wrap with reload, control rules
    push_tick(0);
    push_tick(255);
    push_tick(1);                  // divider crosses its period
    push_write(REG_MOD, 8'hAB);
    push_write(REG_CNT, 8'hFE);
    push_write(REG_CTL, 8'h05);    // timer on, fastest rate
    push_tick(16);
    push_tick(15);
    push_tick(1);                  // counter wraps and reloads
    push_write(REG_CTL, 8'h05);    // same setting, accumulators kept
    push_write(REG_CTL, 8'h01);    // timer off, rate unchanged
    push_tick(255);
    push_write(REG_CTL, 8'h05);    // off to on clears accumulators
    push_write(REG_CTL, 8'h06);    // rate change clears accumulators
    push_tick(64);
    push_write(REG_CTL, 8'h07);
    push_write(REG_CTL, 8'h04);
    push_tick(255);
    push_write(REG_CTL, 8'hFB);    // upper bits kept as written
    push_write(REG_DIV, 8'h5A);    // divider cleared regardless of value
    push_write(REG_CNT, 8'hFF);
    push_write(REG_MOD, 8'h00);
    push_write(REG_CTL, 8'hFF);
    push_tick(255);
    push_tick(1);

    push_mixed(600);

    // long run at the fastest rate drives the counter accumulator to saturation
    push_write(REG_CTL, 8'h05);
    repeat (360) begin
      if ($urandom_range(0, 19) == 0)
        push_write(reg_sel_e'($urandom_range(0, 2)), 8'($urandom));
      else
        push_tick($urandom_range(180, 255));
    end
    repeat (40) push_tick($urandom_range(0, 20));

    push_mixed(100);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst = 0;
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      offer(stim_q.pop_front());
      burst--;
    end
    in_valid_i <= 1'b0;

    while (sb.regs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tt_pkg.sv
hw/rtl/tt_in_stage.sv
hw/rtl/tt_core.sv
hw/rtl/tick_timer_with_reload.sv
hw/rtl/tt_checker.sv
bench/tick_timer_with_reload_tb.sv
